### hw/rtl/arenc_pkg.sv
// ----------------------------------------------------------------------------
// arenc_pkg
// Shared types, command codes and constants of the binary arithmetic encoder.
// ----------------------------------------------------------------------------
package arenc_pkg;

    localparam int unsigned CMD_W     = 2;
    localparam int unsigned SYM_W     = 8;
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned FRAC_W    = FRAC_BITS + 1;
    localparam int unsigned FOLLOW_W  = 16;
    localparam int unsigned MUL_STEPS = FRAC_W;
    localparam int unsigned MCNT_W    = $clog2(MUL_STEPS);

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [FRAC_W-1:0]   t_frac;
    typedef logic [FOLLOW_W-1:0] t_follow;

    localparam t_cmd CMD_LOAD   = 2'd0;
    localparam t_cmd CMD_ENCODE = 2'd1;
    localparam t_cmd CMD_FLUSH  = 2'd2;

    localparam t_frac   FRAC_ONE = t_frac'(1) << FRAC_BITS;
    localparam t_follow PEND_MAX = '1;

    function automatic t_frac sat_frac(input t_frac v);
        return (v > FRAC_ONE) ? FRAC_ONE : v;
    endfunction

    function automatic t_follow pend_inc(input t_follow v);
        return (v == PEND_MAX) ? v : v + t_follow'(1);
    endfunction

endpackage

### hw/rtl/arenc_ram.sv
// ----------------------------------------------------------------------------
// arenc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arenc_ram #(
    parameter int unsigned WIDTH = 34,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/arithmetic_encoder_16bit_unit.sv
// ----------------------------------------------------------------------------
// arithmetic_encoder_16bit_unit
// Static-model binary arithmetic encoder: interval table, shift-add range
// narrowing and E1/E2/E3 renormalization.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  input    i_valid / o_ready    i_command, i_symbol, i_interval_low/high
//  output   o_valid / i_ready    o_code_bit, o_follow_count, o_last, o_bad_symbol
//
//  Load writes the table; flush emits the closing bit. Encode: a table read,
//  two shift-add products (low, then high bound), a check, then one renorm step
//  per cycle (up to PRECISION_BITS+1) unless stalled, plus a closing step.
//  The shared shift-add multiplier sets the encode time.
//  Synchronous active-low reset; the interval table reads empty after reset.
//  While a bit is held, a stalled output transfer holds E1/E2 steps and the close.
// ----------------------------------------------------------------------------
module arithmetic_encoder_16bit_unit
    import arenc_pkg::*;
#(
    parameter int unsigned PRECISION_BITS = 16,
    parameter int unsigned ALPHABET_SIZE  = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [SYM_W-1:0]    i_symbol,
    input  logic [FRAC_W-1:0]   i_interval_low,
    input  logic [FRAC_W-1:0]   i_interval_high,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_code_bit,
    output logic [FOLLOW_W-1:0] o_follow_count,
    output logic                o_last,
    output logic                o_bad_symbol
);

    localparam int unsigned RW     = PRECISION_BITS;
    localparam int unsigned AW     = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int unsigned ACC_W  = RW + FRAC_BITS + 1;
    localparam int unsigned ITER_W = $clog2(PRECISION_BITS + 2);
    localparam int unsigned ENT_W  = 2 * FRAC_W;

    localparam logic [ITER_W-1:0] ITER_END = ITER_W'(PRECISION_BITS + 1);
    localparam logic [MCNT_W-1:0] MUL_LAST = MCNT_W'(MUL_STEPS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_NORM  = 3'd4;
    localparam logic [2:0] S_BAD   = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    logic [2:0]             r_state, n_state;
    logic [RW-1:0]          r_low, n_low;
    logic [RW-1:0]          r_high, n_high;
    t_follow                r_pending, n_pending;
    logic [ALPHABET_SIZE-1:0] r_tbl_vld, n_tbl_vld;
    logic                   r_phase, n_phase;
    logic [MCNT_W-1:0]      r_mcnt, n_mcnt;
    logic [ITER_W-1:0]      r_iter, n_iter;
    logic                   r_hold_vld, n_hold_vld;
    logic                   r_out_vld, n_out_vld;

    logic [ACC_W-1:0]       r_acc, n_acc;
    logic [ACC_W-1:0]       r_mcand, n_mcand;
    t_frac                  r_mplier, n_mplier;
    t_frac                  r_hi_frac, n_hi_frac;
    logic [RW-1:0]          r_nl, n_nl;
    logic                   r_ent_ok, n_ent_ok;
    logic                   r_hold_bit, n_hold_bit;
    t_follow                r_hold_follow, n_hold_follow;
    logic                   r_out_bit, n_out_bit;
    t_follow                r_out_follow, n_out_follow;
    logic                   r_out_last, n_out_last;
    logic                   r_out_bad, n_out_bad;

    logic                   in_xfer;
    logic                   in_range;
    logic [AW-1:0]          sym_idx;
    logic                   out_free;
    logic                   ram_we;
    logic                   ram_re;
    logic [ENT_W-1:0]       ram_wdata;
    logic [ENT_W-1:0]       ram_rdata;
    t_frac                  ent_lo;
    t_frac                  ent_hi;
    logic [RW:0]            rsize;
    logic [ACC_W-1:0]       acc_init;
    logic [ACC_W-1:0]       acc_sum;
    logic [RW:0]            nh;
    logic                   iter_done;
    logic                   e1, e2, e3;

    assign o_ready  = (r_state == S_IDLE);
    assign in_xfer  = i_valid && o_ready;
    assign sym_idx  = i_symbol[AW-1:0];
    assign in_range = ({1'b0, i_symbol} < (SYM_W + 1)'(ALPHABET_SIZE));
    assign out_free = !r_out_vld || i_ready;

    assign ram_we    = in_xfer && (i_command == CMD_LOAD) && in_range;
    assign ram_re    = in_xfer && (i_command == CMD_ENCODE);
    assign ram_wdata = {sat_frac(i_interval_low), sat_frac(i_interval_high)};

    arenc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (sym_idx),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (sym_idx),
        .o_rdata (ram_rdata)
    );

    assign ent_lo    = r_ent_ok ? ram_rdata[ENT_W-1:FRAC_W] : '0;
    assign ent_hi    = r_ent_ok ? ram_rdata[FRAC_W-1:0] : '0;
    assign rsize     = {1'b0, r_high} - {1'b0, r_low} + (RW + 1)'(1);
    assign acc_init  = {1'b0, r_low, FRAC_BITS'(0)};
    assign acc_sum   = r_acc + (r_mplier[0] ? r_mcand : '0);
    assign nh        = r_acc[FRAC_BITS+RW:FRAC_BITS];
    assign iter_done = (r_iter == ITER_END);
    assign e1        = !r_high[RW-1];
    assign e2        = r_low[RW-1];
    assign e3        = !r_low[RW-1] && r_low[RW-2] && r_high[RW-1] && !r_high[RW-2];

    always_comb begin
        n_state       = r_state;
        n_low         = r_low;
        n_high        = r_high;
        n_pending     = r_pending;
        n_tbl_vld     = r_tbl_vld;
        n_phase       = r_phase;
        n_mcnt        = r_mcnt;
        n_iter        = r_iter;
        n_hold_vld    = r_hold_vld;
        n_out_vld     = r_out_vld && !i_ready;
        n_acc         = r_acc;
        n_mcand       = r_mcand;
        n_mplier      = r_mplier;
        n_hi_frac     = r_hi_frac;
        n_nl          = r_nl;
        n_ent_ok      = r_ent_ok;
        n_hold_bit    = r_hold_bit;
        n_hold_follow = r_hold_follow;
        n_out_bit     = r_out_bit;
        n_out_follow  = r_out_follow;
        n_out_last    = r_out_last;
        n_out_bad     = r_out_bad;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (i_command)
                        CMD_LOAD: begin
                            if (in_range) begin
                                n_tbl_vld[sym_idx] = 1'b1;
                            end
                        end
                        CMD_ENCODE: begin
                            n_ent_ok = in_range && r_tbl_vld[sym_idx];
                            n_state  = in_range ? S_READ : S_BAD;
                        end
                        CMD_FLUSH: begin
                            n_state = S_FLUSH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                if (ent_hi <= ent_lo) begin
                    n_state = S_BAD;
                end else begin
                    n_acc     = acc_init;
                    n_mcand   = ACC_W'(rsize);
                    n_mplier  = ent_lo;
                    n_hi_frac = ent_hi;
                    n_phase   = 1'b0;
                    n_mcnt    = '0;
                    n_state   = S_MUL;
                end
            end
            S_MUL: begin
                n_acc    = acc_sum;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_mcnt   = r_mcnt + MCNT_W'(1);
                if (r_mcnt == MUL_LAST) begin
                    n_mcnt = '0;
                    if (!r_phase) begin
                        n_nl     = acc_sum[FRAC_BITS+RW-1:FRAC_BITS];
                        n_acc    = acc_init;
                        n_mcand  = ACC_W'(rsize);
                        n_mplier = r_hi_frac;
                        n_phase  = 1'b1;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (nh <= {1'b0, r_nl}) begin
                    n_state = S_BAD;
                end else begin
                    n_low   = r_nl;
                    n_high  = RW'(nh - (RW + 1)'(1));
                    n_iter  = '0;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (!iter_done && (e1 || e2)) begin
                    if (!r_hold_vld || out_free) begin
                        if (r_hold_vld) begin
                            n_out_vld    = 1'b1;
                            n_out_bit    = r_hold_bit;
                            n_out_follow = r_hold_follow;
                            n_out_last   = 1'b0;
                            n_out_bad    = 1'b0;
                        end
                        n_hold_vld    = 1'b1;
                        n_hold_bit    = !e1;
                        n_hold_follow = r_pending;
                        n_pending     = '0;
                        n_low         = {r_low[RW-2:0], 1'b0};
                        n_high        = {r_high[RW-2:0], 1'b1};
                        n_iter        = r_iter + ITER_W'(1);
                    end
                end else if (!iter_done && e3) begin
                    n_pending = pend_inc(r_pending);
                    n_low     = {1'b0, r_low[RW-3:0], 1'b0};
                    n_high    = {1'b1, r_high[RW-3:0], 1'b1};
                    n_iter    = r_iter + ITER_W'(1);
                end else if (!r_hold_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_bit    = r_hold_bit;
                    n_out_follow = r_hold_follow;
                    n_out_last   = 1'b1;
                    n_out_bad    = 1'b0;
                    n_hold_vld   = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            S_BAD: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_bit    = 1'b0;
                    n_out_follow = '0;
                    n_out_last   = 1'b1;
                    n_out_bad    = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_bit    = r_low[RW-1] || r_low[RW-2];
                    n_out_follow = pend_inc(r_pending);
                    n_out_last   = 1'b1;
                    n_out_bad    = 1'b0;
                    n_low        = '0;
                    n_high       = '1;
                    n_pending    = '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_low      <= '0;
            r_high     <= '1;
            r_pending  <= '0;
            r_tbl_vld  <= '0;
            r_phase    <= 1'b0;
            r_mcnt     <= '0;
            r_iter     <= '0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_low      <= n_low;
            r_high     <= n_high;
            r_pending  <= n_pending;
            r_tbl_vld  <= n_tbl_vld;
            r_phase    <= n_phase;
            r_mcnt     <= n_mcnt;
            r_iter     <= n_iter;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc         <= n_acc;
        r_mcand       <= n_mcand;
        r_mplier      <= n_mplier;
        r_hi_frac     <= n_hi_frac;
        r_nl          <= n_nl;
        r_ent_ok      <= n_ent_ok;
        r_hold_bit    <= n_hold_bit;
        r_hold_follow <= n_hold_follow;
        r_out_bit     <= n_out_bit;
        r_out_follow  <= n_out_follow;
        r_out_last    <= n_out_last;
        r_out_bad     <= n_out_bad;
    end

    assign o_valid        = r_out_vld;
    assign o_code_bit     = r_out_bit;
    assign o_follow_count = r_out_follow;
    assign o_last         = r_out_last;
    assign o_bad_symbol   = r_out_bad;

endmodule

### hw/rtl/arenc_checker.sv
// ----------------------------------------------------------------------------
// arenc_checker
// Port-level checks of the arithmetic encoder, bound to the top level.
// ----------------------------------------------------------------------------
module arenc_checker
    import arenc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic [CMD_W-1:0]    i_command,
    input logic                o_valid,
    input logic                i_ready,
    input logic                o_code_bit,
    input logic [FOLLOW_W-1:0] o_follow_count,
    input logic                o_last,
    input logic                o_bad_symbol
);

    // stalled result transfer holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_code_bit)
            && $stable(o_follow_count) && $stable(o_last) && $stable(o_bad_symbol))
        else $error("output payload changed while stalled");

    // an uncodable symbol ends its item with no bit
    a_bad_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_symbol |-> o_last && !o_code_bit && (o_follow_count == '0))
        else $error("malformed bad_symbol result");

    // a table load produces no result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_command == CMD_LOAD) && !o_valid |=> !o_valid)
        else $error("load produced a result");

    // encode and flush leave the input side busy in the cycle after their transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && ((i_command == CMD_ENCODE) || (i_command == CMD_FLUSH))
            |=> !o_ready)
        else $error("ready right after encode or flush transfer");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("output valid or input not ready after reset");

endmodule

bind arithmetic_encoder_16bit_unit arenc_checker u_arenc_checker (.*);
